// File: hw/rtl/fpdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdt_pkg
// Shared types and constants of the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package fpdt_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam int          CFG_WIDTH = 4;
   localparam logic [3:0]  CFG_RESET = 4'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INT,
      ST_POINT,
      ST_FRAC,
      ST_SETUP,
      ST_OUT,
      ST_DRAIN
   } fpdt_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture the request value
      logic int_step;   // produce one integer digit
      logic point;      // write the decimal point
      logic frac_step;  // produce one fraction digit
      logic out_setup;  // latch rounding decision, set up readout
      logic rd_en;      // read one character out of the buffer
   } fpdt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic int_last;   // current integer step is the units digit
      logic rd_last;    // current read address is the last character
      logic pipe_busy;  // readout pipeline still holds a character
   } fpdt_status_type;

   // Powers of ten, evaluated at elaboration.
   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

// File: hw/rtl/fpdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/fpdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdt_ctrl
// Sequencer: integer digits, point, fraction digits, then character readout.
// Also holds the fraction digit count register.
// ----------------------------------------------------------------------------
module fpdt_ctrl #(
   parameter int MAX_FRACTION_DIGITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        csr_write_en,
   input  logic [fpdt_pkg::CFG_WIDTH-1:0] csr_write_data,
   input  fpdt_pkg::fpdt_status_type   status,
   output fpdt_pkg::fpdt_cmd_type      cmd
);

   localparam logic [fpdt_pkg::CFG_WIDTH-1:0] MAX_FD =
      fpdt_pkg::CFG_WIDTH'(MAX_FRACTION_DIGITS);

   fpdt_pkg::fpdt_state_type state_ff, state_in;

   logic [fpdt_pkg::CFG_WIDTH-1:0] cfg_ff, cfg_in;
   logic [fpdt_pkg::CFG_WIDTH-1:0] kc_ff, kc_in;
   logic [fpdt_pkg::CFG_WIDTH-1:0] fd;
   logic                           frac_done;

   assign fd        = (cfg_ff > MAX_FD) ? MAX_FD : cfg_ff;
   assign frac_done = (kc_ff == fd - fpdt_pkg::CFG_WIDTH'(1));

   always_comb begin
      cfg_in = csr_write_en ? csr_write_data : cfg_ff;
   end

   always_comb begin
      kc_in = kc_ff;
      if (state_ff == fpdt_pkg::ST_POINT) begin
         kc_in = '0;
      end else if (state_ff == fpdt_pkg::ST_FRAC) begin
         kc_in = kc_ff + fpdt_pkg::CFG_WIDTH'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpdt_pkg::ST_IDLE: begin
            if (start) state_in = fpdt_pkg::ST_INT;
         end
         fpdt_pkg::ST_INT: begin
            if (status.int_last) begin
               state_in = (fd != '0) ? fpdt_pkg::ST_POINT : fpdt_pkg::ST_SETUP;
            end
         end
         fpdt_pkg::ST_POINT: begin
            state_in = fpdt_pkg::ST_FRAC;
         end
         fpdt_pkg::ST_FRAC: begin
            if (frac_done) state_in = fpdt_pkg::ST_SETUP;
         end
         fpdt_pkg::ST_SETUP: begin
            state_in = fpdt_pkg::ST_OUT;
         end
         fpdt_pkg::ST_OUT: begin
            if (status.rd_last) state_in = fpdt_pkg::ST_DRAIN;
         end
         fpdt_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) state_in = fpdt_pkg::ST_IDLE;
         end
         default: begin
            state_in = fpdt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         fpdt_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         fpdt_pkg::ST_INT:   cmd.int_step  = 1'b1;
         fpdt_pkg::ST_POINT: cmd.point     = 1'b1;
         fpdt_pkg::ST_FRAC:  cmd.frac_step = 1'b1;
         fpdt_pkg::ST_SETUP: cmd.out_setup = 1'b1;
         fpdt_pkg::ST_OUT:   cmd.rd_en     = 1'b1;
         fpdt_pkg::ST_DRAIN: cmd           = '0;
         default:            cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpdt_pkg::ST_IDLE;
         cfg_ff   <= fpdt_pkg::CFG_RESET;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
      kc_ff <= kc_in;
   end

endmodule

// File: hw/rtl/fpdt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdt_dp
// Datapath: magnitude and saturation, digit extraction, text buffer and
// readout with on-the-fly rounding.
// Buffer layout: address 0 sign, address 1 carry-out '1', digits from 2.
// ----------------------------------------------------------------------------
module fpdt_dp #(
   parameter int MAX_FRACTION_DIGITS = 12,
   parameter int INTEGER_DIGITS      = 10,
   parameter int FRACTION_BITS       = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [63:0]        req_value,
   input  fpdt_pkg::fpdt_cmd_type    cmd,
   output fpdt_pkg::fpdt_status_type status,
   output logic                      rsp_strobe,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_last_char
);

   localparam int DEPTH = 3 + INTEGER_DIGITS + MAX_FRACTION_DIGITS;
   localparam int AW    = $clog2(DEPTH);
   localparam longint unsigned INT_LIMIT = fpdt_pkg::pow10(INTEGER_DIGITS) - 64'd1;
   localparam int IW    = $clog2(INT_LIMIT + 64'd1);
   localparam int PW    = (INTEGER_DIGITS > 1) ? $clog2(INTEGER_DIGITS) : 1;
   localparam int FB    = FRACTION_BITS;

   localparam logic [AW-1:0] ADDR_SIGN  = AW'(0);
   localparam logic [AW-1:0] ADDR_CARRY = AW'(1);
   localparam logic [AW-1:0] ADDR_FIRST = AW'(2);

   // k * 10^p constant table
   logic [IW-1:0] mult_tab [INTEGER_DIGITS][1:9];

   for (genvar g = 0; g < INTEGER_DIGITS; g++) begin : g_pow
      for (genvar k = 1; k <= 9; k++) begin : g_mul
         assign mult_tab[g][k] = IW'(64'(k) * fpdt_pkg::pow10(g));
      end
   end

   logic          neg_ff, neg_in;
   logic [IW-1:0] r_ff, r_in;
   logic [FB-1:0] frac_ff, frac_in;
   logic [PW-1:0] p_ff, p_in;
   logic          started_ff, started_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [AW-1:0] nn_ff, nn_in;
   logic          nn_valid_ff, nn_valid_in;
   logic          has_frac_ff, has_frac_in;
   logic          round_ff, round_in;
   logic          ins_ff, ins_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] ra_ff, ra_in;
   logic          rdv_ff, rdv_in;
   logic [AW-1:0] rab_ff, rab_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    char_ff, char_in;
   logic          lastc_ff, lastc_in;

   logic [63:0]   mag;
   logic [63:0]   ipart;
   logic          sat;
   logic [3:0]    dig;
   logic [IW-1:0] sub;
   logic          int_wr;
   logic [FB+3:0] tprod;
   logic          we;
   logic [7:0]    wdata;
   logic [7:0]    rdata;
   logic          round_c;
   logic [AW-1:0] ra_next;

   // load: magnitude and saturation of the integer part
   assign mag   = req_value[63] ? (~req_value + 64'd1) : req_value;
   assign ipart = mag >> FB;
   assign sat   = ipart > INT_LIMIT;

   // one integer digit: largest k with k * 10^p <= remainder
   always_comb begin
      dig = '0;
      sub = '0;
      for (int k = 1; k <= 9; k++) begin
         if (r_ff >= mult_tab[p_ff][k]) begin
            dig = 4'(k);
            sub = mult_tab[p_ff][k];
         end
      end
   end

   assign int_wr = started_ff || (dig != '0) || (p_ff == '0);
   assign tprod  = (FB + 4)'(frac_ff) * (FB + 4)'(10);

   always_comb begin
      we    = 1'b0;
      wdata = fpdt_pkg::CHAR_POINT;
      if (cmd.int_step) begin
         we    = int_wr;
         wdata = fpdt_pkg::CHAR_ZERO + {4'd0, dig};
      end else if (cmd.frac_step) begin
         we    = 1'b1;
         wdata = fpdt_pkg::CHAR_ZERO + {4'd0, tprod[FB+3:FB]};
      end else if (cmd.point) begin
         we    = 1'b1;
         wdata = fpdt_pkg::CHAR_POINT;
      end
   end

   assign round_c = has_frac_ff && frac_ff[FB-1];

   always_comb begin
      neg_in      = neg_ff;
      r_in        = r_ff;
      frac_in     = frac_ff;
      p_in        = p_ff;
      started_in  = started_ff;
      wa_in       = wa_ff;
      nn_in       = nn_ff;
      nn_valid_in = nn_valid_ff;
      has_frac_in = has_frac_ff;
      round_in    = round_ff;
      ins_in      = ins_ff;
      last_in     = last_ff;
      ra_in       = ra_ff;

      if (cmd.load) begin
         neg_in      = req_value[63];
         r_in        = sat ? IW'(INT_LIMIT) : IW'(ipart);
         frac_in     = sat ? '1 : mag[FB-1:0];
         p_in        = PW'(INTEGER_DIGITS - 1);
         started_in  = 1'b0;
         wa_in       = ADDR_FIRST;
         nn_valid_in = 1'b0;
         has_frac_in = 1'b0;
      end
      if (cmd.int_step) begin
         r_in       = r_ff - sub;
         p_in       = p_ff - PW'(1);
         started_in = int_wr;
      end
      if (cmd.frac_step) begin
         frac_in = tprod[FB-1:0];
      end
      if (cmd.point) begin
         has_frac_in = 1'b1;
      end
      if (we) begin
         wa_in = wa_ff + AW'(1);
         // remember the last digit that a rounding carry would stop on
         if (wdata != fpdt_pkg::CHAR_POINT && wdata != fpdt_pkg::CHAR_NINE) begin
            nn_in       = wa_ff;
            nn_valid_in = 1'b1;
         end
      end
      if (cmd.out_setup) begin
         round_in = round_c;
         ins_in   = round_c && !nn_valid_ff;
         last_in  = wa_ff - AW'(1);
         if (neg_ff) begin
            ra_in = ADDR_SIGN;
         end else if (round_c && !nn_valid_ff) begin
            ra_in = ADDR_CARRY;
         end else begin
            ra_in = ADDR_FIRST;
         end
      end
      if (cmd.rd_en) begin
         ra_in = ra_next;
      end
   end

   always_comb begin
      ra_next = ra_ff + AW'(1);
      if (ra_next == ADDR_CARRY && !ins_ff) begin
         ra_next = ADDR_FIRST;
      end
   end

   fpdt_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_buf (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wa_ff),
      .wr_data(wdata),
      .rd_en  (cmd.rd_en),
      .rd_addr(ra_ff),
      .rd_data(rdata)
   );

   assign rdv_in = cmd.rd_en;
   assign rab_in = ra_ff;

   // character map with the rounding carry applied
   always_comb begin
      strobe_in = rdv_ff;
      lastc_in  = (rab_ff == last_ff);
      char_in   = rdata;
      if (rab_ff == ADDR_SIGN) begin
         char_in = fpdt_pkg::CHAR_MINUS;
      end else if (rab_ff == ADDR_CARRY) begin
         char_in = fpdt_pkg::CHAR_ONE;
      end else if (round_ff) begin
         if (ins_ff || rab_ff > nn_ff) begin
            if (rdata != fpdt_pkg::CHAR_POINT) char_in = fpdt_pkg::CHAR_ZERO;
         end else if (rab_ff == nn_ff) begin
            char_in = rdata + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         rdv_ff    <= rdv_in;
         strobe_ff <= strobe_in;
      end
      neg_ff      <= neg_in;
      r_ff        <= r_in;
      frac_ff     <= frac_in;
      p_ff        <= p_in;
      started_ff  <= started_in;
      wa_ff       <= wa_in;
      nn_ff       <= nn_in;
      nn_valid_ff <= nn_valid_in;
      has_frac_ff <= has_frac_in;
      round_ff    <= round_in;
      ins_ff      <= ins_in;
      last_ff     <= last_in;
      ra_ff       <= ra_in;
      rab_ff      <= rab_in;
      char_ff     <= char_in;
      lastc_ff    <= lastc_in;
   end

   assign status.int_last  = (p_ff == '0);
   assign status.rd_last   = (ra_ff == last_ff);
   assign status.pipe_busy = rdv_ff;

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = lastc_ff;

endmodule

// File: hw/rtl/fixed_point_to_decimal_text_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_text_top
// Signed fixed-point number to decimal ASCII text, one character per result.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then
// steps through every integer digit position (leading zeros included), the
// point and each fraction digit when the precision is above zero, and a
// setup step, and then streams the characters of the text on consecutive
// cycles, rsp_last_char marking the last one. Busy stays high until the last
// character has left the registered text buffer readout and been strobed.
// Results cannot be held off: each is valid only in its strobe cycle.
// csr_write_data sets the number of fraction digits (reset 6, capped at
// MAX_FRACTION_DIGITS); write it only while busy is low.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_text_top #(
   parameter int MAX_FRACTION_DIGITS = 12,
   parameter int INTEGER_DIGITS      = 10,
   parameter int FRACTION_BITS       = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [63:0]             req_value,
   output logic                           rsp_strobe,
   output logic [7:0]                     rsp_out_char,
   output logic                           rsp_last_char,
   input  logic                           csr_write_en,
   input  logic [fpdt_pkg::CFG_WIDTH-1:0] csr_write_data
);

   fpdt_pkg::fpdt_cmd_type    cmd;
   fpdt_pkg::fpdt_status_type status;

   fpdt_ctrl #(
      .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .status        (status),
      .cmd           (cmd)
   );

   fpdt_dp #(
      .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
      .INTEGER_DIGITS     (INTEGER_DIGITS),
      .FRACTION_BITS      (FRACTION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_char (rsp_out_char),
      .rsp_last_char(rsp_last_char)
   );

endmodule

// File: hw/rtl/fpdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdt_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module fpdt_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_last_char
);

   // characters of one number come on consecutive cycles
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_char |=> rsp_strobe)
      else $error("character stream broke before last character");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside a busy period");

   a_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_strobe && rsp_last_char))
      else $error("busy dropped without a last character");

   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_char |=> !rsp_strobe)
      else $error("result right after last character");

endmodule

bind fixed_point_to_decimal_text_top fpdt_checker u_fpdt_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_last_char(rsp_last_char)
);

// File: tb/sv/tb_fixed_point_to_decimal_text_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_to_decimal_text_top
// Checks the fixed-point to decimal text converter character by character.
// Every accepted request is turned into its expected text by a bit-exact
// predictor and queued; each strobed character is compared with the oldest
// queued one. The run sweeps the precision register (0, 12, above the cap and
// random settings), uses directed rounding and sign cases and then random
// values with random or no gaps between requests.
// ----------------------------------------------------------------------------
class decimal_text_board;
   localparam int          FRAC_BITS  = 32;
   localparam int          INT_DIGITS = 10;
   localparam int          MAX_FD     = 12;
   localparam logic [63:0] FRAC_MASK  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] HALF       = 64'h0000_0000_8000_0000;
   localparam logic [63:0] INT_LIMIT  = 64'd9999999999;

   logic [3:0] precision;
   logic [7:0] text_q[$];
   bit         last_q[$];
   int         errors;

   function new();
      precision = fpdt_pkg::CFG_RESET;
      errors    = 0;
   endfunction

   function void report(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
   endfunction

   function int pending();
      return text_q.size();
   endfunction

   // Builds the text for one accepted request and queues its characters.
   function void note_request(logic signed [63:0] value);
      logic [63:0] mag, ipart, frac, prod;
      logic [7:0]  text [0:24];
      logic [7:0]  rev [0:9];
      int          pos, first, nd, fd, i, k;
      bit          neg, carrying;
      neg   = value[63];
      mag   = neg ? 64'd0 - value : value;
      ipart = mag >> FRAC_BITS;
      frac  = mag & FRAC_MASK;
      if (ipart > INT_LIMIT) begin
         ipart = INT_LIMIT;
         frac  = FRAC_MASK;
      end
      fd  = (precision > MAX_FD) ? MAX_FD : precision;
      pos = 0;
      nd  = 0;
      if (neg) begin
         text[pos] = fpdt_pkg::CHAR_MINUS;
         pos++;
      end
      first = pos;
      do begin
         rev[nd] = fpdt_pkg::CHAR_ZERO + 8'(ipart % 10);
         ipart   = ipart / 10;
         nd++;
      end while (ipart != 0 && nd < INT_DIGITS);
      for (i = nd - 1; i >= 0; i--) begin
         text[pos] = rev[i];
         pos++;
      end
      if (fd > 0) begin
         text[pos] = fpdt_pkg::CHAR_POINT;
         pos++;
         for (k = 0; k < fd; k++) begin
            prod      = frac * 10;
            text[pos] = fpdt_pkg::CHAR_ZERO + 8'(prod >> FRAC_BITS);
            pos++;
            frac = prod & FRAC_MASK;
         end
         if (frac >= HALF) begin
            // carry ripples left over nines, skipping the point
            i        = pos - 1;
            carrying = 1'b1;
            while (carrying && i >= first) begin
               if (text[i] == fpdt_pkg::CHAR_POINT) begin
                  i--;
               end else if (text[i] == fpdt_pkg::CHAR_NINE) begin
                  text[i] = fpdt_pkg::CHAR_ZERO;
                  i--;
               end else begin
                  text[i]  = text[i] + 8'd1;
                  carrying = 1'b0;
               end
            end
            if (carrying) begin
               for (k = pos; k > first; k--) text[k] = text[k-1];
               text[first] = fpdt_pkg::CHAR_ONE;
               pos++;
            end
         end
      end
      for (k = 0; k < pos; k++) begin
         text_q.push_back(text[k]);
         last_q.push_back(k == pos - 1);
      end
   endfunction

   function void check_result(logic [7:0] ch, logic last);
      logic [7:0] exp_ch;
      bit         exp_last;
      if (text_q.size() == 0) begin
         report($sformatf("unexpected character '%c' (last %0b)", ch, last));
         return;
      end
      exp_ch   = text_q.pop_front();
      exp_last = last_q.pop_front();
      if (ch !== exp_ch || last !== exp_last)
         report($sformatf("char mismatch: expected '%c' last %0b, got '%c' (%h) last %0b",
                          exp_ch, exp_last, ch, ch, last));
   endfunction
endclass

module tb_fixed_point_to_decimal_text_top;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [63:0] req_value;
   logic               rsp_strobe;
   logic [7:0]         rsp_out_char;
   logic               rsp_last_char;
   logic               csr_write_en;
   logic [fpdt_pkg::CFG_WIDTH-1:0] csr_write_data;

   decimal_text_board board = new();

   fixed_point_to_decimal_text_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_char  (rsp_last_char),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_out_char, rsp_last_char);
   end

   // start stays high across back-to-back requests; it drops for a gap and in wait_drained
   task automatic send_value(input logic signed [63:0] value, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      board.note_request(value);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
   endtask

   task automatic set_precision(input logic [3:0] digits);
      wait_drained();
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= digits;
      @(posedge clock);
      csr_write_en    <= 1'b0;
      board.precision  = digits;
   endtask

   function automatic logic signed [63:0] fixed_value(input bit neg, input logic [31:0] ipart,
                                                      input logic [31:0] frac);
      logic [63:0] mag;
      mag = {ipart, frac};
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [63:0] random_value();
      logic [31:0] ipart;
      bit          neg;
      neg = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return fixed_value(neg, $urandom_range(0, 99), $urandom);
         2: begin
            // fraction just below one: long carry chains
            case ($urandom_range(0, 3))
               0: ipart = 32'd9;
               1: ipart = 32'd999999999;
               2: ipart = 32'h7FFF_FFFF;
               default: ipart = $urandom_range(0, 32'h7FFF_FFFF);
            endcase
            return fixed_value(neg, ipart, 32'hFFFF_FFFF - $urandom_range(0, 4000));
         end
         3: return fixed_value(neg, $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 31),
                               $urandom >> $urandom_range(0, 31));
         4: return fixed_value(neg, 32'd0, $urandom_range(0, 10000));
         default: begin
            case ($urandom_range(0, 2))
               0: return 64'sh8000_0000_0000_0000;
               1: return 64'sh7FFF_FFFF_FFFF_FFFF;
               default: return -64'sh7FFF_FFFF_FFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic signed [63:0] at_reset_prec [$];
      logic signed [63:0] at_zero_prec [$];
      logic signed [63:0] at_max_prec [$];
      logic [3:0]         digits;
      bit                 steady;
      int                 gap;

      reset          = 1'b1;
      start          = 1'b0;
      req_value      = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;

      at_reset_prec = '{
         64'sd0,
         64'sd1,
         -64'sd1,
         64'sh7FFF_FFFF_FFFF_FFFF,
         64'sh8000_0000_0000_0000,
         64'sh0000_0001_0000_0000,
         -64'sh0000_0001_0000_0000,
         64'sh0000_0000_8000_0000,
         64'sh0000_0009_FFFF_FFFF,
         -64'sh0000_0009_FFFF_FFFF,
         fixed_value(1'b0, 32'd999999999, 32'hFFFF_FF00),
         fixed_value(1'b0, 32'h7FFF_FFFF, 32'd0),
         fixed_value(1'b1, 32'd1234, 32'h8000_0000),
         64'sd2148,
         64'sd2147
      };
      at_zero_prec = '{
         64'sh7FFF_FFFF_FFFF_FFFF,
         -64'sh0000_0000_8000_0000,
         64'sh0000_0009_FFFF_FFFF,
         64'sh8000_0000_0000_0000
      };
      at_max_prec = '{
         64'sh7FFF_FFFF_FFFF_FFFF,
         64'sd1,
         -64'sh0000_0000_FFFF_FFFF
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (at_reset_prec[n]) send_value(at_reset_prec[n], $urandom_range(0, 3));
      set_precision(4'd0);
      foreach (at_zero_prec[n]) send_value(at_zero_prec[n], 0);
      set_precision(4'd12);
      foreach (at_max_prec[n]) send_value(at_max_prec[n], $urandom_range(0, 18));

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: digits = 4'd15;
            1: digits = 4'd13;
            2: digits = 4'd0;
            3: digits = 4'd1;
            default: digits = 4'($urandom_range(0, 15));
         endcase
         set_precision(digits);
         steady = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < 13; n++) begin
            gap = steady ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 24) == 0) wait_drained();
            send_value(random_value(), gap);
         end
      end

      wait_drained();
      repeat (80) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #500us;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/fpdt_pkg.sv
hw/rtl/fpdt_ram.sv
hw/rtl/fpdt_ctrl.sv
hw/rtl/fpdt_dp.sv
hw/rtl/fixed_point_to_decimal_text_top.sv
hw/rtl/fpdt_checker.sv
tb/sv/tb_fixed_point_to_decimal_text_top.sv
